>>> rtl/core/cidr_pkg.sv
// Shared types, constants and mask helper for the CIDR membership block.
// No dependencies; imported by every module under rtl/core.
package cidr_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int ENTRY_AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Queue depths (powers of two)
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_AW      = $clog2(CMDQ_DEPTH);
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 4;
  localparam int RQ_AW      = $clog2(RESQ_DEPTH);
  localparam int RQ_CW      = $clog2(RESQ_DEPTH + 1);

  // Full prefix lengths per version
  localparam logic [7:0] V4_FULL_LEN = 8'd32;
  localparam logic [7:0] V6_FULL_LEN = 8'd128;

  // Opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // Classified command from front end to back end
  typedef struct packed {
    logic [1:0]   op;
    logic         is_v6;
    logic [127:0] addr;
    logic [7:0]   len;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic matched;
    logic status;
  } res_t;

  // Back-end status for checks at the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             s1_valid;
    logic [RQ_CW-1:0] resq_cnt;
  } bk_stat_t;

  // Build a 128-bit prefix mask; IPv4 masks live in bits 31..0.
  function automatic logic [127:0] prefix_mask(input logic is_v6, input logic [7:0] len);
    logic [127:0] m;
    for (int i = 0; i < 128; i++) begin
      if (is_v6) begin
        m[i] = (int'(len) + i) >= 128;
      end else begin
        m[i] = (i < 32) && ((int'(len) + i) >= 32);
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/cidr_front.sv
// Front end: accepts input transactions, clamps the prefix, clears unused IPv4 bits and masks load addresses.
// Depends on cidr_pkg; feeds cidr_cmd_q.
module cidr_front
  import cidr_pkg::*;
(
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic        in_is_v6,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_prefix_len,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [7:0]   full_len;
  logic [7:0]   clamp_len;
  logic [127:0] canon_addr;

  // Accept whenever the command queue has room
  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  // Clamp prefix length to the version width
  assign full_len  = in_is_v6 ? V6_FULL_LEN : V4_FULL_LEN;
  assign clamp_len = (in_prefix_len > full_len) ? full_len : in_prefix_len;

  // Drop unused upper bits for IPv4
  assign canon_addr = in_is_v6 ? {in_addr_hi, in_addr_lo} : {96'd0, in_addr_lo[31:0]};

  // Mask stored ranges to their prefix
  always_comb begin
    q_cmd.op    = in_opcode;
    q_cmd.is_v6 = in_is_v6;
    q_cmd.len   = clamp_len;
    q_cmd.addr  = canon_addr;
    if (in_opcode == OP_LOAD) begin
      q_cmd.addr = canon_addr & prefix_mask(in_is_v6, clamp_len);
    end
  end

endmodule

>>> rtl/core/cidr_cmd_q.sv
// Short command queue between front end and back end.
// Depends on cidr_pkg for cmd_t and depth constants.
module cidr_cmd_q
  import cidr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  output logic valid,
  output cmd_t dout,
  input  logic pop
);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CQ_CW'(CMDQ_DEPTH));
  assign valid   = (count_r != '0);
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/core/cidr_back.sv
// Back end: range table, parallel prefix compares, match reduction, result queue.
// Depends on cidr_pkg; fed by cidr_cmd_q.
module cidr_back
  import cidr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  cmd_t     cmd,
  output logic     cmd_pop,
  input  logic     out_pop,
  output logic     out_empty,
  output logic     out_matched,
  output logic     out_status,
  output bk_stat_t stat
);

  // Range table, each entry compared at its own place
  logic [127:0]       ent_addr_r  [MAX_ENTRIES];
  logic [7:0]         ent_len_r   [MAX_ENTRIES];
  logic               ent_v6_r    [MAX_ENTRIES];
  logic [CNT_W-1:0]   count_r, count_nxt;

  // Compare stage
  logic                   s1_valid_r;
  logic [MAX_ENTRIES-1:0] s1_hit_r;
  logic                   s1_status_r;
  logic [MAX_ENTRIES-1:0] hit;
  logic                   tbl_full;
  logic                   issue;
  logic                   do_load;

  // Result queue
  res_t             rq_mem_r [RESQ_DEPTH];
  logic [RQ_AW-1:0] rq_wr_r, rq_rd_r;
  logic [RQ_CW-1:0] rq_cnt_r, rq_cnt_nxt;
  logic             rq_push, rq_pop;
  res_t             rq_din;

  // Issue only with room reserved for everything in flight
  assign issue    = cmd_valid &&
                    ((RQ_CW+1)'(rq_cnt_r) + (RQ_CW+1)'(s1_valid_r) < (RQ_CW+1)'(RESQ_DEPTH));
  assign cmd_pop  = issue;
  assign tbl_full = (count_r == CNT_W'(MAX_ENTRIES));
  assign do_load  = issue && (cmd.op == OP_LOAD) && !tbl_full;

  // Compare lookup address against every live entry of the same version
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit[i] = (cmd.op == OP_LOOKUP) && (CNT_W'(i) < count_r) &&
               (ent_v6_r[i] == cmd.is_v6) &&
               (((cmd.addr ^ ent_addr_r[i]) & prefix_mask(ent_v6_r[i], ent_len_r[i])) == '0);
    end
  end

  // Update entry count
  always_comb begin
    count_nxt = count_r;
    if (issue) begin
      case (cmd.op)
        OP_LOAD:  if (!tbl_full) count_nxt = count_r + 1'b1;
        OP_CLEAR: count_nxt = '0;
        default:  count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      s1_valid_r <= issue;
    end
  end

  // Write the appended entry
  always_ff @(posedge clk) begin
    if (do_load) begin
      ent_addr_r[count_r[ENTRY_AW-1:0]] <= cmd.addr;
      ent_len_r[count_r[ENTRY_AW-1:0]]  <= cmd.len;
      ent_v6_r[count_r[ENTRY_AW-1:0]]   <= cmd.is_v6;
    end
  end

  // Register per-entry hits and load status
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_hit_r    <= hit;
      s1_status_r <= (cmd.op == OP_LOAD) && tbl_full;
    end
  end

  // Reduce hits and queue the result
  assign rq_din.matched = |s1_hit_r;
  assign rq_din.status  = s1_status_r;
  assign rq_push        = s1_valid_r;
  assign rq_pop         = out_pop && !out_empty;

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (rq_push && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + 1'b1;
    end else if (rq_pop && !rq_push) begin
      rq_cnt_nxt = rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (rq_push) rq_wr_r <= rq_wr_r + 1'b1;
      if (rq_pop)  rq_rd_r <= rq_rd_r + 1'b1;
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_mem_r[rq_wr_r] <= rq_din;
    end
  end

  assign out_empty   = (rq_cnt_r == '0);
  assign out_matched = rq_mem_r[rq_rd_r].matched;
  assign out_status  = rq_mem_r[rq_rd_r].status;

  assign stat.count    = count_r;
  assign stat.s1_valid = s1_valid_r;
  assign stat.resq_cnt = rq_cnt_r;

endmodule

>>> rtl/core/cidr_list_membership_match.sv
// CIDR range membership table, IPv4 and IPv6, up to MAX_ENTRIES ranges.
// A result passes through the command queue, the compare stage and the result
// queue before it can be popped.
// Throughput: one item per cycle while results are popped; the result queue
// occupancy plus the compare stage sets when the back end issues.
// Reset (rst_n low, synchronous) empties both queues and the table count.
module cidr_list_membership_match
  import cidr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic        in_is_v6,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_prefix_len,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_matched,
  output logic        out_status
);

  logic     q_full, q_push, q_valid, q_pop;
  cmd_t     q_cmd_in, q_cmd_out;
  bk_stat_t bk_stat;

  cidr_front u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_is_v6      (in_is_v6),
    .in_addr_hi    (in_addr_hi),
    .in_addr_lo    (in_addr_lo),
    .in_prefix_len (in_prefix_len),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd_in)
  );

  cidr_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_cmd_in),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_cmd_out),
    .pop   (q_pop)
  );

  cidr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd         (q_cmd_out),
    .cmd_pop     (q_pop),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_matched (out_matched),
    .out_status  (out_status),
    .stat        (bk_stat)
  );

  // Table count never passes its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.count <= CNT_W'(MAX_ENTRIES))
    else $error("table count above capacity");

  // Results in flight always fit in the result queue
  a_resq_room: assert property (@(posedge clk) disable iff (!rst_n)
    ((RQ_CW+1)'(bk_stat.resq_cnt) + (RQ_CW+1)'(bk_stat.s1_valid)) <=
    (RQ_CW+1)'(RESQ_DEPTH))
    else $error("result queue overcommitted");

  // Reset leaves an empty table and no result
  a_reset_clear: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (bk_stat.count == '0 && out_empty))
    else $error("state not cleared by reset");

endmodule
